// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes for the stable priority event queue: request kinds,
// result status codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Request kinds
  localparam logic KIND_POST = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Fixed field widths
  localparam int PRIO_W     = 8;
  localparam int ID_W       = 16;
  localparam int PORT_DATA_W = 32;
  localparam int FILL_W     = 5;

endpackage

`default_nettype wire

// ===== rtl/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Entry memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 56,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/stable_priority_event_queue_core.sv =====
// Sequencing: a pop passes S_POP, then S_OUT; a post into a non-empty queue walks S_CMP past
// each larger entry (at most QUEUE_DEPTH - 1), via S_NEW if it reaches the head, to S_OUT; a
// post into an empty queue, a dropped post and a pop on empty go straight to S_OUT.
// The walk is set by the single read port and single write port of the entry RAM.
// One item is in work at a time; the next is taken in the cycle after the result is staged.
// Reset: synchronous, active low; the queue comes up empty, RAM is not cleared.
// ----------------------------------------------------------------------------
// stable_priority_event_queue_core
// Bounded priority queue kept sorted in a circular RAM. A post walks from
// the tail toward the head, moving larger entries one slot back; a pop
// reads the head entry and advances the head pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_event_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_BITS   = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [spq_pkg::PRIO_W-1:0]   in_event_priority,
  input  wire logic [spq_pkg::ID_W-1:0]     in_event_id,
  input  wire logic [spq_pkg::PORT_DATA_W-1:0] in_event_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [spq_pkg::PRIO_W-1:0]        out_priority,
  output logic [spq_pkg::ID_W-1:0]          out_id,
  output logic [spq_pkg::PORT_DATA_W-1:0]   out_data,
  output logic [spq_pkg::FILL_W-1:0]        out_fill
);

  import spq_pkg::*;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int AW      = IDX_W + 1;
  localparam int ENTRY_W = PRIO_W + ID_W + DATA_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_NEW  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [ENTRY_W-1:0]    new_r, new_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [ENTRY_W-1:0]    res_entry_r, res_entry_nxt;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [ENTRY_W-1:0]    out_entry_r;
  logic [FILL_W-1:0]     out_fill_r;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0]    wdata, rdata;
  logic [CNT_W-1:0]      rd_off;
  logic [PRIO_W-1:0]     rd_prio, new_prio;
  logic                  in_xfer, out_free;

  // Map an offset from the head onto a RAM index
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [AW-1:0] sum;
    sum = AW'(head) + AW'(off);
    if (sum >= AW'(QUEUE_DEPTH)) begin
      sum = sum - AW'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_prio  = rdata[ENTRY_W-1 -: PRIO_W];
  assign new_prio = new_r[ENTRY_W-1 -: PRIO_W];

  spq_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Choose the read offset: head for a pop, tail for a post, next lower while walking
  always_comb begin
    if (state_r == S_CMP) begin
      rd_off = j_r - CNT_W'(2);
    end else if (in_kind == KIND_POP) begin
      rd_off = '0;
    end else begin
      rd_off = cnt_r - CNT_W'(1);
    end
  end
  assign raddr = slot(head_r, rd_off);

  // Sequence one item through the RAM
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    j_nxt          = j_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    we             = 1'b0;
    waddr          = head_r;
    wdata          = new_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          new_nxt       = {in_event_priority, in_event_id, DATA_BITS'(in_event_data)};
          res_entry_nxt = '0;
          res_status_nxt = ST_DONE;
          if (in_kind == KIND_POP) begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              state_nxt = S_POP;
            end
          end else if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_OUT;
          end else if (cnt_r == '0) begin
            we        = 1'b1;
            waddr     = head_r;
            wdata     = {in_event_priority, in_event_id, DATA_BITS'(in_event_data)};
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_OUT;
          end else begin
            j_nxt     = cnt_r;
            state_nxt = S_CMP;
          end
        end
      end
      S_POP: begin
        res_entry_nxt = rdata;
        head_nxt      = slot(head_r, CNT_W'(1));
        cnt_nxt       = cnt_r - CNT_W'(1);
        state_nxt     = S_OUT;
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = slot(head_r, j_r);
        if (rd_prio > new_prio) begin
          // Move the larger entry one slot back and keep walking
          wdata = rdata;
          j_nxt = j_r - CNT_W'(1);
          state_nxt = (j_r == CNT_W'(1)) ? S_NEW : S_CMP;
        end else begin
          wdata     = new_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_OUT;
        end
      end
      S_NEW: begin
        we        = 1'b1;
        waddr     = head_r;
        wdata     = new_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold payload and stage the result
  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    if (state_r == S_OUT && out_free) begin
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_fill_r   <= FILL_W'(cnt_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_priority = out_entry_r[ENTRY_W-1 -: PRIO_W];
  assign out_id       = out_entry_r[DATA_BITS +: ID_W];
  assign out_data     = PORT_DATA_W'(out_entry_r[DATA_BITS-1:0]);
  assign out_fill     = out_fill_r;

endmodule

`default_nettype wire
